// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file tcd_checker.sv.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define TCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define TCD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define TCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tcd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcd_pkg
// Types and constants of the triangle circumdiameter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    localparam int QUOT_W = 32;
    localparam int LIMIT_W = 32;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd429497;
    localparam int MUL_CHUNK = 16;

    typedef struct packed {
        logic degenerate;
        logic overflow;
    } div_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcd_vertex_if.sv -----
// ----------------------------------------------------------------------------
// tcd_vertex_if
// Valid/ready channel that carries one triangle as three 3D vertices.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcd_vertex_if #(
    parameter int COORD_WIDTH = 24
);
    logic valid;
    logic ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
    logic signed [COORD_WIDTH-1:0] third_z;

    modport source (
        output valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, first_z, second_x, second_y, second_z,
               third_x, third_y, third_z,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/tcd_result_if.sv -----
// ----------------------------------------------------------------------------
// tcd_result_if
// Valid/ready channel that carries one circumdiameter result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcd_result_if;
    import tcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [QUOT_W-1:0] diameter;
    logic              degenerate;
    logic              saturated;

    modport source (output valid, diameter, degenerate, saturated, input ready);
    modport sink   (input valid, diameter, degenerate, saturated, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tcd_isqrt_pipe.sv -----
// ----------------------------------------------------------------------------
// tcd_isqrt_pipe
// Truncated integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_isqrt_pipe #(
    parameter int IN_W = 52,
    parameter int SIDE_W = 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [IN_W-1:0]        radicand,
    input  wire logic [SIDE_W-1:0]      side_in,
    output logic                        out_valid,
    output logic [IN_W/2-1:0]           root,
    output logic [SIDE_W-1:0]           side_out
);

    localparam int OUT_W = IN_W / 2;

    logic              valid_reg [0:OUT_W-1];
    logic [IN_W-1:0]   rad_reg   [0:OUT_W-1];
    logic [OUT_W-1:0]  root_reg  [0:OUT_W-1];
    logic [OUT_W+1:0]  rem_reg   [0:OUT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:OUT_W-1];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic              valid_in;
        logic [IN_W-1:0]   rad_in;
        logic [OUT_W-1:0]  root_in;
        logic [OUT_W+1:0]  rem_in;
        logic [SIDE_W-1:0] side_in_k;
        logic [OUT_W+1:0]  cur;
        logic [OUT_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign valid_in  = in_valid;
            assign rad_in    = radicand;
            assign root_in   = '0;
            assign rem_in    = '0;
            assign side_in_k = side_in;
        end else begin : g_rest
            assign valid_in  = valid_reg[k-1];
            assign rad_in    = rad_reg[k-1];
            assign root_in   = root_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        always_comb
        begin
            cur   = {rem_in[OUT_W-1:0], rad_in[IN_W-1:IN_W-2]};
            trial = {root_in, 2'b01};
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_in << 2;
                root_reg[k] <= {root_in[OUT_W-2:0], ge};
                rem_reg[k]  <= ge ? (cur - trial) : cur;
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign side_out  = side_reg[OUT_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/tcd_mul_pipe.sv -----
// ----------------------------------------------------------------------------
// tcd_mul_pipe
// Wide unsigned multiplier that adds one partial product of a 16-bit chunk of op_b per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_mul_pipe #(
    parameter int A_W = 36,
    parameter int B_W = 36,
    parameter int SIDE_W = 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [A_W-1:0]     op_a,
    input  wire logic [B_W-1:0]     op_b,
    input  wire logic [SIDE_W-1:0]  side_in,
    output logic                    out_valid,
    output logic [A_W+B_W-1:0]      product,
    output logic [SIDE_W-1:0]       side_out
);
    import tcd_pkg::*;

    localparam int NCH = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BPW = NCH * MUL_CHUNK;
    localparam int PPW = A_W + BPW;

    logic              valid_reg [0:NCH-1];
    logic [A_W-1:0]    a_reg     [0:NCH-1];
    logic [BPW-1:0]    b_reg     [0:NCH-1];
    logic [PPW-1:0]    acc_reg   [0:NCH-1];
    logic [SIDE_W-1:0] side_reg  [0:NCH-1];

    for (genvar k = 0; k < NCH; k++) begin : g_stage
        logic                     valid_in;
        logic [A_W-1:0]           a_in;
        logic [BPW-1:0]           b_in;
        logic [PPW-1:0]           acc_in;
        logic [SIDE_W-1:0]        side_in_k;
        logic [MUL_CHUNK-1:0]     chunk;
        logic [A_W+MUL_CHUNK-1:0] pp;

        if (k == 0) begin : g_first
            assign valid_in  = in_valid;
            assign a_in      = op_a;
            assign b_in      = BPW'(op_b);
            assign acc_in    = '0;
            assign side_in_k = side_in;
        end else begin : g_rest
            assign valid_in  = valid_reg[k-1];
            assign a_in      = a_reg[k-1];
            assign b_in      = b_reg[k-1];
            assign acc_in    = acc_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        always_comb
        begin
            chunk = b_in[k*MUL_CHUNK +: MUL_CHUNK];
            pp    = a_in * chunk;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a_reg[k]    <= a_in;
                b_reg[k]    <= b_in;
                acc_reg[k]  <= acc_in + (PPW'(pp) << (k * MUL_CHUNK));
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_valid = valid_reg[NCH-1];
    assign product   = acc_reg[NCH-1][A_W+B_W-1:0];
    assign side_out  = side_reg[NCH-1];

endmodule

`default_nettype wire

// ----- hw/rtl/tcd_div_pipe.sv -----
// ----------------------------------------------------------------------------
// tcd_div_pipe
// Restoring divider with a 32-bit quotient, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_div_pipe #(
    parameter int CW = 104,
    parameter int SIDE_W = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_valid,
    input  wire logic [CW-1:0]      num,
    input  wire logic [CW-1:0]      den,
    input  wire logic [SIDE_W-1:0]  side_in,
    output logic                    out_valid,
    output logic [tcd_pkg::QUOT_W-1:0] quotient,
    output logic [SIDE_W-1:0]       side_out
);
    import tcd_pkg::*;

    logic              valid_reg [0:QUOT_W-1];
    logic [CW-1:0]     rem_reg   [0:QUOT_W-1];
    logic [CW-1:0]     den_reg   [0:QUOT_W-1];
    logic [QUOT_W-1:0] q_reg     [0:QUOT_W-1];
    logic [SIDE_W-1:0] side_reg  [0:QUOT_W-1];

    for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
        logic              valid_in;
        logic [CW-1:0]     rem_in;
        logic [CW-1:0]     den_in;
        logic [QUOT_W-1:0] q_in;
        logic [SIDE_W-1:0] side_in_k;
        logic [CW-1:0]     sh;
        logic              ge;

        if (k == 0) begin : g_first
            assign valid_in  = in_valid;
            assign rem_in    = num;
            assign den_in    = den;
            assign q_in      = '0;
            assign side_in_k = side_in;
        end else begin : g_rest
            assign valid_in  = valid_reg[k-1];
            assign rem_in    = rem_reg[k-1];
            assign den_in    = den_reg[k-1];
            assign q_in      = q_reg[k-1];
            assign side_in_k = side_reg[k-1];
        end

        always_comb
        begin
            sh = den_in << (QUOT_W - 1 - k);
            ge = (rem_in >= sh);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? (rem_in - sh) : rem_in;
                den_reg[k]  <= den_in;
                q_reg[k]    <= {q_in[QUOT_W-2:0], ge};
                side_reg[k] <= side_in_k;
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quotient  = q_reg[QUOT_W-1];
    assign side_out  = side_reg[QUOT_W-1];

endmodule

`default_nettype wire

// ----- hw/rtl/triangle_circumdiameter.sv -----
// ----------------------------------------------------------------------------
// triangle_circumdiameter: circumcircle diameter of a 3D triangle (Heron).
// One item per cycle sustained while the output item is taken. The pipeline
// stalls as a whole while the output item waits; reset clears all valid bits
// and loads the degenerate limit with its default.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_circumdiameter #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [tcd_pkg::LIMIT_W-1:0]   cfg_wdata,
    tcd_vertex_if.sink                         vertices,
    tcd_result_if.source                       result
);
    import tcd_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int SQW  = 2 * DW;
    localparam int SUMW = SQW + 2;
    localparam int SW   = SUMW / 2;
    localparam int FW   = SW + 2;
    localparam int PW   = 2 * FW;
    localparam int PRW  = 2 * PW;
    localparam int AW   = PRW - 4;
    localparam int RW   = AW / 2;
    localparam int ABW  = 2 * SW;
    localparam int NW   = ABW + SW;
    localparam int DENW = RW + 1;
    localparam int CW   = (NW > DENW + QUOT_W + 1) ? NW : DENW + QUOT_W + 1;

    logic en;
    logic out_valid_reg;
    logic [QUOT_W-1:0] diameter_reg;
    logic degenerate_reg;
    logic saturated_reg;
    logic [LIMIT_W-1:0] limit_reg;

    assign en = !out_valid_reg || result.ready;
    assign vertices.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_wdata;
        end
    end

    // Differences for sides a (v0-v1), b (v1-v2), c (v2-v0).
    logic signed [W-1:0] vtx [0:2][0:2];
    assign vtx[0][0] = vertices.first_x;
    assign vtx[0][1] = vertices.first_y;
    assign vtx[0][2] = vertices.first_z;
    assign vtx[1][0] = vertices.second_x;
    assign vtx[1][1] = vertices.second_y;
    assign vtx[1][2] = vertices.second_z;
    assign vtx[2][0] = vertices.third_x;
    assign vtx[2][1] = vertices.third_y;
    assign vtx[2][2] = vertices.third_z;

    logic           s1_valid_reg;
    logic [DW-1:0]  mag_reg [0:2][0:2];
    logic           s2_valid_reg;
    logic [SQW-1:0] sq_reg  [0:2][0:2];
    logic           s3_valid_reg;
    logic [SUMW-1:0] dist_reg [0:2];

    for (genvar s = 0; s < 3; s++) begin : g_side
        for (genvar j = 0; j < 3; j++) begin : g_axis
            logic signed [DW-1:0] dif;
            logic [DW-1:0] mag_next;
            always_comb
            begin
                dif = DW'(vtx[s][j]) - DW'(vtx[(s + 1) % 3][j]);
                mag_next = dif[DW-1] ? $unsigned(-dif) : $unsigned(dif);
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    mag_reg[s][j] <= mag_next;
                    sq_reg[s][j]  <= mag_reg[s][j] * mag_reg[s][j];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dist_reg[s] <= SUMW'(sq_reg[s][0]) + SUMW'(sq_reg[s][1])
                               + SUMW'(sq_reg[s][2]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= vertices.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    logic          sides_valid;
    logic [SW-1:0] side_a, side_b, side_c;

    tcd_isqrt_pipe #(.IN_W(SUMW), .SIDE_W(1)) u_sqrt_a (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg),
        .radicand(dist_reg[0]), .side_in(1'b0),
        .out_valid(sides_valid), .root(side_a), .side_out()
    );
    tcd_isqrt_pipe #(.IN_W(SUMW), .SIDE_W(1)) u_sqrt_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg),
        .radicand(dist_reg[1]), .side_in(1'b0),
        .out_valid(), .root(side_b), .side_out()
    );
    tcd_isqrt_pipe #(.IN_W(SUMW), .SIDE_W(1)) u_sqrt_c (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_valid_reg),
        .radicand(dist_reg[2]), .side_in(1'b0),
        .out_valid(), .root(side_c), .side_out()
    );

    // Heron factors; a broken triangle inequality gives a zero area.
    logic          s4_valid_reg;
    logic [FW-1:0] sum_reg, f1_reg, f2_reg, f3_reg;
    logic [SW-1:0] a4_reg, b4_reg, c4_reg;
    logic [FW-1:0] ea, eb, ec;
    logic          broken;

    always_comb
    begin
        ea = FW'(side_a);
        eb = FW'(side_b);
        ec = FW'(side_c);
        broken = (ea > eb + ec) || (eb > ea + ec) || (ec > ea + eb);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= broken ? '0 : ea + eb + ec;
            f1_reg  <= broken ? '0 : eb + ec - ea;
            f2_reg  <= broken ? '0 : ea + ec - eb;
            f3_reg  <= broken ? '0 : ea + eb - ec;
            a4_reg  <= side_a;
            b4_reg  <= side_b;
            c4_reg  <= side_c;
        end
    end

    logic           s5_valid_reg;
    logic [PW-1:0]  p1_reg, p2_reg;
    logic [ABW-1:0] ab5_reg;
    logic [SW-1:0]  c5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= sum_reg * f1_reg;
            p2_reg  <= f2_reg * f3_reg;
            ab5_reg <= a4_reg * b4_reg;
            c5_reg  <= c4_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= sides_valid;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    logic           prod_valid;
    logic [PRW-1:0] prod;
    logic [ABW+SW-1:0] prod_side;

    tcd_mul_pipe #(.A_W(PW), .B_W(PW), .SIDE_W(ABW + SW)) u_mul_heron (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s5_valid_reg),
        .op_a(p1_reg), .op_b(p2_reg), .side_in({ab5_reg, c5_reg}),
        .out_valid(prod_valid), .product(prod), .side_out(prod_side)
    );

    // Squared area as an unsigned integer (Q.0) and the degenerate decision.
    logic           s6_valid_reg;
    logic [AW-1:0]  area_reg;
    logic           deg6_reg;
    logic [ABW+SW-1:0] side6_reg;
    logic [AW-1:0]  area_next;

    assign area_next = prod[PRW-1:4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            area_reg  <= area_next;
            deg6_reg  <= (area_next < AW'(limit_reg)) || (area_next == '0);
            side6_reg <= prod_side;
        end
    end

    logic          root_valid;
    logic [RW-1:0] area_root;
    logic [ABW+SW:0] root_side;

    tcd_isqrt_pipe #(.IN_W(AW), .SIDE_W(ABW + SW + 1)) u_sqrt_area (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s6_valid_reg),
        .radicand(area_reg), .side_in({deg6_reg, side6_reg}),
        .out_valid(root_valid), .root(area_root), .side_out(root_side)
    );

    logic          num_valid;
    logic [NW-1:0] abc;
    logic [RW:0]   num_side;

    tcd_mul_pipe #(.A_W(ABW), .B_W(SW), .SIDE_W(RW + 1)) u_mul_abc (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(root_valid),
        .op_a(root_side[ABW+SW-1:SW]), .op_b(root_side[SW-1:0]),
        .side_in({root_side[ABW+SW], area_root}),
        .out_valid(num_valid), .product(abc), .side_out(num_side)
    );

    // Overflow check against twice the root shifted by the quotient width.
    logic          s7_valid_reg;
    logic [CW-1:0] num7_reg, den7_reg;
    div_flags_t    flags7_reg;
    logic [CW-1:0] num_ext, den_ext;

    assign num_ext = CW'(abc);
    assign den_ext = CW'({num_side[RW-1:0], 1'b0});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num7_reg <= num_ext;
            den7_reg <= den_ext;
            flags7_reg.degenerate <= num_side[RW];
            flags7_reg.overflow   <= (num_ext >= (den_ext << QUOT_W));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s6_valid_reg <= prod_valid;
            s7_valid_reg <= num_valid;
        end
    end

    logic              div_valid;
    logic [QUOT_W-1:0] quot;
    div_flags_t        div_flags;

    tcd_div_pipe #(.CW(CW), .SIDE_W($bits(div_flags_t))) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s7_valid_reg),
        .num(num7_reg), .den(den7_reg), .side_in(flags7_reg),
        .out_valid(div_valid), .quotient(quot), .side_out(div_flags)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (div_flags.degenerate)
            begin
                diameter_reg   <= '0;
                degenerate_reg <= 1'b1;
                saturated_reg  <= 1'b0;
            end
            else if (div_flags.overflow)
            begin
                diameter_reg   <= '1;
                degenerate_reg <= 1'b0;
                saturated_reg  <= 1'b1;
            end
            else
            begin
                diameter_reg   <= quot;
                degenerate_reg <= 1'b0;
                saturated_reg  <= 1'b0;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.diameter   = diameter_reg;
    assign result.degenerate = degenerate_reg;
    assign result.saturated  = saturated_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tcd_checker.sv -----
// ----------------------------------------------------------------------------
// tcd_checker
// Port-level assertions for the circumdiameter pipeline, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tcd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] diameter,
    input wire logic        degenerate,
    input wire logic        saturated
);

    // Input is taken exactly when the output register can move.
    `TCD_ASSERT(a_ready_follows_output, in_ready == (!out_valid || out_ready), "ready mismatch")
    `TCD_ASSERT_IMPL(a_degenerate_zero, out_valid && degenerate,
        diameter == 32'd0 && !saturated, "degenerate item with nonzero diameter")
    `TCD_ASSERT_IMPL(a_saturated_max, out_valid && saturated,
        diameter == 32'hFFFFFFFF, "saturated item below maximum")
    `TCD_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready,
        out_valid && $stable(diameter) && $stable(degenerate) && $stable(saturated),
        "stalled item changed")

endmodule

bind triangle_circumdiameter tcd_checker u_tcd_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_ready(vertices.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .diameter(result.diameter),
    .degenerate(result.degenerate),
    .saturated(result.saturated)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle circumdiameter testbench
// Streams triangles through the valid/ready vertex channel with bursty
// sending and a stalling receiver, predicts each diameter with exact wide
// integer arithmetic, and compares every result item in order. The degenerate
// limit is rewritten between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tcd_pkg::*;

    localparam int CW = 24;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD = 400;
    localparam int DRAIN_CYCLES = 200;

    typedef logic [8:0][CW-1:0] triangle_t;
    typedef struct packed {
        logic [QUOT_W-1:0] diameter;
        logic              degenerate;
        logic              saturated;
    } circ_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;
    logic [LIMIT_W-1:0] limit_shadow;

    tcd_vertex_if #(.COORD_WIDTH(CW)) vtx();
    tcd_result_if res();

    triangle_circumdiameter #(.COORD_WIDTH(CW)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .vertices  (vtx),
        .result    (res)
    );

    triangle_t pending_tris[$];
    circ_t     expected_circs[$];
    int        errors = 0;
    int        received = 0;
    int        idle_cycles = 0;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] root_of(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int i = 63; i >= 0; i--)
        begin
            cand = r | (64'd1 << i);
            if ({64'd0, cand} * {64'd0, cand} <= n)
                r = cand;
        end
        return r;
    endfunction

    function automatic logic [63:0] side_len(input logic [CW-1:0] px, py, pz,
                                              input logic [CW-1:0] qx, qy, qz);
        longint dx;
        longint dy;
        longint dz;
        logic [127:0] acc;
        dx = longint'($signed(px)) - longint'($signed(qx));
        dy = longint'($signed(py)) - longint'($signed(qy));
        dz = longint'($signed(pz)) - longint'($signed(qz));
        acc = 128'(dx * dx) + 128'(dy * dy) + 128'(dz * dz);
        return root_of(acc);
    endfunction

    function automatic circ_t circumdiameter(input triangle_t t, input logic [LIMIT_W-1:0] lim);
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  c;
        logic [127:0] area;
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quot;
        logic [63:0]  root;
        circ_t        r;
        a = side_len(t[0], t[1], t[2], t[3], t[4], t[5]);
        b = side_len(t[3], t[4], t[5], t[6], t[7], t[8]);
        c = side_len(t[6], t[7], t[8], t[0], t[1], t[2]);
        if (a > b + c || b > a + c || c > a + b)
            area = '0;
        else
            area = ((128'(a + b + c) * 128'(b + c - a)) * 128'(a + c - b)
                    * 128'(a + b - c)) >> 4;
        root = root_of(area);
        r = '0;
        if (area < 128'(lim) || root == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        num = 128'(a) * 128'(b) * 128'(c);
        den = 128'(root) * 2;
        quot = num / den;
        if (quot[127:32] != 0)
        begin
            r.diameter = '1;
            r.saturated = 1'b1;
        end
        else
            r.diameter = quot[31:0];
        return r;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtx.valid <= 1'b0;
            {vtx.first_x, vtx.first_y, vtx.first_z, vtx.second_x, vtx.second_y,
             vtx.second_z, vtx.third_x, vtx.third_y, vtx.third_z} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (vtx.valid && vtx.ready)
            begin
                expected_circs = {expected_circs,
                                  circumdiameter(pending_tris[0], limit_shadow)};
                void'(pending_tris.pop_front());
            end
            if (!(vtx.valid && !vtx.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    vtx.valid <= 1'b0;
                end
                else if (pending_tris.size() > 0)
                begin
                    vtx.valid <= 1'b1;
                    {vtx.third_z, vtx.third_y, vtx.third_x, vtx.second_z, vtx.second_y,
                     vtx.second_x, vtx.first_z, vtx.first_y, vtx.first_x} <= pending_tris[0];
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    vtx.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall mode is redrawn at random as rx_cycle advances, with one long hold early on.
    int  rx_cycle = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                stall_mode <= $urandom_range(0, 3);
            if (!hold_done && received >= 40)
            begin
                hold_done <= 1;
                hold_left <= LONG_HOLD;
                res.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res.ready <= 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: res.ready <= 1'b1;
                    1: res.ready <= $urandom_range(0, 1);
                    2: res.ready <= (rx_cycle % 4 != 0);
                    default: res.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            received <= received + 1;
            if (expected_circs.size() == 0)
            begin
                $display("%0t: unexpected result item diameter=%h degenerate=%b saturated=%b",
                         $time, res.diameter, res.degenerate, res.saturated);
                errors <= errors + 1;
            end
            else
            begin
                if (res.diameter !== expected_circs[0].diameter
                    || res.degenerate !== expected_circs[0].degenerate
                    || res.saturated !== expected_circs[0].saturated)
                begin
                    $display("%0t: mismatch expected diameter=%h degenerate=%b saturated=%b",
                             $time, expected_circs[0].diameter, expected_circs[0].degenerate,
                             expected_circs[0].saturated);
                    $display("%0t:          actual   diameter=%h degenerate=%b saturated=%b",
                             $time, res.diameter, res.degenerate, res.saturated);
                    errors <= errors + 1;
                end
                void'(expected_circs.pop_front());
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog timeout", $time);
            $display("FAIL triangle_circumdiameter");
            $finish;
        end
    end

    function automatic triangle_t make_tri(input int x0, y0, z0, x1, y1, z1, x2, y2, z2);
        triangle_t t;
        t[0] = CW'(x0); t[1] = CW'(y0); t[2] = CW'(z0);
        t[3] = CW'(x1); t[4] = CW'(y1); t[5] = CW'(z1);
        t[6] = CW'(x2); t[7] = CW'(y2); t[8] = CW'(z2);
        return t;
    endfunction

    function automatic int rnd_coord(input int span);
        if (span >= CW)
            return int'($signed(CW'($urandom())));
        return int'($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
    endfunction

    function automatic triangle_t random_tri();
        triangle_t t;
        int kind;
        int span;
        int mx;
        int my;
        int mz;
        kind = $urandom_range(0, 9);
        span = (kind < 3) ? CW : $urandom_range(4, 20);
        for (int i = 0; i < 9; i++)
            t[i] = CW'(rnd_coord(span));
        if (kind == 8)
        begin
            mx = (int'($signed(t[0])) + int'($signed(t[3]))) / 2;
            my = (int'($signed(t[1])) + int'($signed(t[4]))) / 2;
            mz = (int'($signed(t[2])) + int'($signed(t[5]))) / 2;
            t[6] = CW'(mx + $urandom_range(0, 2) - 1);
            t[7] = CW'(my + $urandom_range(0, 2) - 1);
            t[8] = CW'(mz);
        end
        else if (kind == 9)
        begin
            t[6] = t[0];
            t[7] = t[1];
            t[8] = t[2];
        end
        return t;
    endfunction

    task automatic add_tri(input triangle_t t);
        pending_tris = {pending_tris, t};
    endtask

    task automatic wait_idle();
        while (pending_tris.size() != 0 || expected_circs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        limit_shadow <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        for (int i = 0; i < n; i++)
            add_tri(random_tri());
    endtask

    localparam int MX = 8388607;
    localparam int MN = -8388608;

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        limit_shadow = LIMIT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_tri(make_tri(0, 0, 0, 256, 0, 0, 512, 0, 0));
        add_tri(make_tri(0, 0, 0, 768, 0, 0, 0, 1024, 0));
        add_tri(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
        add_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        add_tri(make_tri(MN, MN, MN, MX, MX, MX, MN, MX, MN));
        add_tri(make_tri(MX, MN, MX, MN, MX, MN, MX, MX, MN));
        add_tri(make_tri(MN, 0, 0, MX, 0, 0, 0, 1, 0));
        add_tri(make_tri(MN, MN, 0, MX, MX, 0, 0, 1, 0));
        add_tri(make_tri(0, 0, 0, 3, 0, 0, 1, 1, 0));
        add_tri(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 3));
        add_tri(make_tri(-1, -1, -1, -1, -1, -1, 5, 5, 5));
        add_tri(make_tri(100, 200, 300, -400, 500, -600, 700, -800, 900));
        queue_random(150);

        write_limit('0);
        add_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_tri(make_tri(0, 0, 0, 256, 0, 0, 512, 0, 0));
        add_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
        add_tri(make_tri(MN, 0, 0, MX, 0, 0, 0, 1, 0));
        add_tri(make_tri(0, 0, 0, 2, 0, 0, 1, 1, 0));
        queue_random(130);

        write_limit('1);
        add_tri(make_tri(MN, MN, MN, MX, MX, MX, MN, MX, MN));
        queue_random(40);

        write_limit(LIMIT_W'($urandom()) >> $urandom_range(0, 31));
        queue_random(130);

        write_limit(32'd1);
        queue_random(40);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("PASS triangle_circumdiameter");
        else
            $display("FAIL triangle_circumdiameter");
        $finish;
    end
endmodule

`default_nettype wire
